// ===== hdl/usp_pkg.sv =====
package usp_pkg;

  // defaults for top-level parameters
  localparam int MAX_URL_LEN_DEFAULT = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // results one byte or end command can cause
  localparam int EV_SLOTS = 3;

  // output field widths
  localparam int OFF_W = 12;
  localparam int LEN_W = 13;

  // characters with a meaning to the parser
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  // input command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // register index of the event enable mask
  localparam logic REG_EVENT_MASK = 1'b0;

  typedef enum logic [3:0] {
    EV_BEGIN    = 4'd0,
    EV_SCHEME   = 4'd1,
    EV_HOST     = 4'd2,
    EV_PORT     = 4'd3,
    EV_SEGMENT  = 4'd4,
    EV_PATH     = 4'd5,
    EV_KV       = 4'd6,
    EV_COMPLETE = 4'd7,
    EV_ERROR    = 4'd8
  } event_t;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_SCHEME   = 4'd1,
    ST_SLASH1   = 4'd2,
    ST_SLASH2   = 4'd3,
    ST_HOST     = 4'd4,
    ST_PRECOLON = 4'd5,
    ST_PORT     = 4'd6,
    ST_SEGMENT  = 4'd7,
    ST_KEY      = 4'd8,
    ST_VALUE    = 4'd9,
    ST_ERROR    = 4'd10
  } parse_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       event_res;
    logic [OFF_W-1:0] span_start;
    logic [LEN_W-1:0] span_len;
    logic [OFF_W-1:0] value_start;
    logic [LEN_W-1:0] value_len;
    logic             last;
  } out_item_t;

  // one event, already saturated
  typedef struct packed {
    event_t           code;
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] vstart;
    logic [LEN_W-1:0] vlen;
  } ev_t;

  // all events of one input item, packed from slot 0
  typedef struct packed {
    logic [1:0]            count;
    ev_t [EV_SLOTS-1:0]    evs;
  } bundle_t;

  // characters allowed in a url
  function automatic logic legal_byte(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
    case (c)
      8'h2D, 8'h2E, 8'h5F, CH_TILDE, CH_COLON, CH_SLASH, CH_QUESTION,
      8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24, CH_AMP,
      8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B,
      CH_EQUALS: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

// ===== hdl/usp_front.sv =====
module usp_front import usp_pkg::*; #(
  parameter int MAX_URL_LEN = MAX_URL_LEN_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  input  logic [7:0] event_mask,
  output logic     push,
  output bundle_t  bundle
);

  localparam int PW = $clog2(MAX_URL_LEN + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_URL_LEN);

  parse_state_t st, st_next;
  logic [PW-1:0] position, position_next;
  logic [PW-1:0] scheme_start, scheme_start_next;
  logic [PW-1:0] host_start, host_start_next, host_len, host_len_next;
  logic [PW-1:0] port_start, port_start_next, port_len, port_len_next;
  logic [PW-1:0] path_base, path_base_next, path_len, path_len_next;
  logic [PW-1:0] seg_start, seg_start_next, seg_len, seg_len_next;
  logic [PW-1:0] key_start, key_start_next, key_len, key_len_next;
  logic [PW-1:0] value_begin, value_begin_next, value_count, value_count_next;

  logic       err;
  logic [7:0] c;
  logic [PW-1:0] p;
  ev_t        raw [EV_SLOTS];
  logic [EV_SLOTS-1:0] raw_v;

  assign c = item.ch;
  assign p = position;

  // saturate an offset to the output width
  function automatic logic [OFF_W-1:0] sat_off(input logic [PW-1:0] v);
    return (32'(v) > 32'd4095) ? {OFF_W{1'b1}} : OFF_W'(v);
  endfunction

  // saturate a length to the output width
  function automatic logic [LEN_W-1:0] sat_len(input logic [PW-1:0] v);
    return (32'(v) > 32'd8191) ? {LEN_W{1'b1}} : LEN_W'(v);
  endfunction

  function automatic ev_t mk_ev(input event_t code, input logic [PW-1:0] s,
                                input logic [PW-1:0] l);
    ev_t e;
    e.code   = code;
    e.start  = sat_off(s);
    e.len    = sat_len(l);
    e.vstart = '0;
    e.vlen   = '0;
    return e;
  endfunction

  // error detection for the current item
  always_comb begin
    err = 1'b0;
    if (item.cmd == CMD_END) begin
      err = !(st == ST_SEGMENT || st == ST_VALUE || st == ST_HOST || st == ST_PORT);
    end else if (st != ST_ERROR) begin
      if (p >= MAX_POS || !legal_byte(c)) err = 1'b1;
      else if ((st == ST_SLASH1 || st == ST_SLASH2) && c != CH_SLASH) err = 1'b1;
      else if (st == ST_PRECOLON && c == CH_SLASH) err = 1'b1;
    end
  end

  // next parse state
  always_comb begin
    st_next = st;
    if (item.cmd == CMD_END) begin
      st_next = ST_START;
    end else if (st != ST_ERROR) begin
      if (err) begin
        st_next = ST_ERROR;
      end else begin
        case (st)
          ST_START:    st_next = (c == CH_SLASH) ? ST_SEGMENT : ST_SCHEME;
          ST_SCHEME:   if (c == CH_COLON) st_next = ST_SLASH1;
          ST_SLASH1:   st_next = ST_SLASH2;
          ST_SLASH2:   st_next = ST_HOST;
          ST_HOST: begin
            if (c == CH_COLON) st_next = ST_PRECOLON;
            else if (c == CH_SLASH) st_next = ST_SEGMENT;
          end
          ST_PRECOLON: st_next = ST_PORT;
          ST_PORT:     if (c == CH_SLASH) st_next = ST_SEGMENT;
          ST_SEGMENT:  if (c == CH_QUESTION) st_next = ST_KEY;
          ST_KEY:      if (c == CH_EQUALS) st_next = ST_VALUE;
          ST_VALUE:    if (c == CH_AMP) st_next = ST_KEY;
          default:     st_next = ST_ERROR;
        endcase
      end
    end
  end

  // field span updates
  always_comb begin
    position_next     = position;
    scheme_start_next = scheme_start;
    host_start_next   = host_start;
    host_len_next     = host_len;
    port_start_next   = port_start;
    port_len_next     = port_len;
    path_base_next    = path_base;
    path_len_next     = path_len;
    seg_start_next    = seg_start;
    seg_len_next      = seg_len;
    key_start_next    = key_start;
    key_len_next      = key_len;
    value_begin_next  = value_begin;
    value_count_next  = value_count;
    if (item.cmd == CMD_END) begin
      position_next     = '0;
      scheme_start_next = '0;
      host_start_next   = '0;
      host_len_next     = '0;
      port_start_next   = '0;
      port_len_next     = '0;
      path_base_next    = '0;
      path_len_next     = '0;
      seg_start_next    = '0;
      seg_len_next      = '0;
      key_start_next    = '0;
      key_len_next      = '0;
      value_begin_next  = '0;
      value_count_next  = '0;
    end else if (st != ST_ERROR) begin
      if (p < MAX_POS) position_next = p + 1'b1;
      if (!err) begin
        case (st)
          ST_START: begin
            if (c == CH_SLASH) begin
              path_base_next = p;
              path_len_next  = path_len + 1'b1;
              seg_start_next = p + 1'b1;
            end else begin
              scheme_start_next = p;
            end
          end
          ST_SLASH2: host_start_next = p + 1'b1;
          ST_HOST: begin
            if (c == CH_SLASH) begin
              path_base_next = p;
              path_len_next  = path_len + 1'b1;
              seg_start_next = p + 1'b1;
            end else if (c != CH_COLON) begin
              host_len_next = host_len + 1'b1;
            end
          end
          ST_PRECOLON: begin
            port_start_next = p;
            port_len_next   = PW'(1);
          end
          ST_PORT: begin
            if (c == CH_SLASH) begin
              path_base_next = p;
              path_len_next  = path_len + 1'b1;
              seg_start_next = p + 1'b1;
            end else begin
              port_len_next = port_len + 1'b1;
            end
          end
          ST_SEGMENT: begin
            if (c == CH_SLASH || c == CH_QUESTION) begin
              seg_start_next = p + 1'b1;
              seg_len_next   = '0;
            end else begin
              seg_len_next = seg_len + 1'b1;
            end
            if (c == CH_QUESTION) begin
              key_start_next = p + 1'b1;
              key_len_next   = '0;
            end else begin
              path_len_next = path_len + 1'b1;
            end
          end
          ST_KEY: begin
            if (c == CH_EQUALS) begin
              value_begin_next = p + 1'b1;
              value_count_next = '0;
            end else begin
              key_len_next = key_len + 1'b1;
            end
          end
          ST_VALUE: begin
            if (c == CH_AMP) begin
              key_start_next = p + 1'b1;
              key_len_next   = '0;
            end else begin
              value_count_next = value_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // raw events in order, before the enable mask
  always_comb begin
    ev_t kv;
    kv        = mk_ev(EV_KV, key_start, key_len);
    kv.vstart = sat_off(value_begin);
    kv.vlen   = sat_len(value_count);
    for (int i = 0; i < EV_SLOTS; i++) raw[i] = '0;
    raw_v = '0;
    if (item.cmd == CMD_END) begin
      if (err) begin
        raw[0] = mk_ev(EV_ERROR, p, '0);
        raw_v  = 3'b001;
      end else begin
        case (st)
          ST_SEGMENT: begin
            raw[0] = mk_ev(EV_SEGMENT, seg_start, seg_len);
            raw[1] = mk_ev(EV_PATH, path_base, path_len);
            raw[2] = mk_ev(EV_COMPLETE, '0, p);
            raw_v  = 3'b111;
          end
          ST_VALUE: begin
            raw[0] = kv;
            raw[1] = mk_ev(EV_COMPLETE, '0, p);
            raw_v  = 3'b011;
          end
          ST_HOST: begin
            raw[0] = mk_ev(EV_HOST, host_start, host_len);
            raw[1] = mk_ev(EV_COMPLETE, '0, p);
            raw_v  = 3'b011;
          end
          ST_PORT: begin
            raw[0] = mk_ev(EV_PORT, port_start, port_len);
            raw[1] = mk_ev(EV_COMPLETE, '0, p);
            raw_v  = 3'b011;
          end
          default: ;
        endcase
      end
    end else if (st != ST_ERROR) begin
      if (err) begin
        raw[0] = mk_ev(EV_ERROR, p, '0);
        raw_v  = 3'b001;
      end else begin
        case (st)
          ST_START: begin
            raw[0] = mk_ev(EV_BEGIN, '0, '0);
            raw_v  = 3'b001;
          end
          ST_SCHEME: begin
            raw[0] = mk_ev(EV_SCHEME, scheme_start, p - scheme_start);
            raw_v  = {2'b00, c == CH_COLON};
          end
          ST_HOST: begin
            raw[0] = mk_ev(EV_HOST, host_start, host_len);
            raw_v  = {2'b00, c == CH_COLON || c == CH_SLASH};
          end
          ST_PORT: begin
            raw[0] = mk_ev(EV_PORT, port_start, port_len);
            raw_v  = {2'b00, c == CH_SLASH};
          end
          ST_SEGMENT: begin
            raw[0] = mk_ev(EV_SEGMENT, seg_start, seg_len);
            raw[1] = mk_ev(EV_PATH, path_base, path_len);
            raw_v  = {1'b0, c == CH_QUESTION, c == CH_SLASH || c == CH_QUESTION};
          end
          ST_VALUE: begin
            raw[0] = kv;
            raw_v  = {2'b00, c == CH_AMP};
          end
          default: ;
        endcase
      end
    end
  end

  // drop disabled events and pack the rest from slot 0
  always_comb begin
    logic [1:0] n;
    logic       en;
    n      = '0;
    bundle = '0;
    for (int i = 0; i < EV_SLOTS; i++) begin
      en = (raw[i].code == EV_ERROR) || event_mask[raw[i].code[2:0]];
      if (raw_v[i] && en) begin
        bundle.evs[n] = raw[i];
        n = n + 1'b1;
      end
    end
    bundle.count = n;
  end

  assign push = accept && (bundle.count != 2'd0);

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_START;
      position     <= '0;
      scheme_start <= '0;
      host_start   <= '0;
      host_len     <= '0;
      port_start   <= '0;
      port_len     <= '0;
      path_base    <= '0;
      path_len     <= '0;
      seg_start    <= '0;
      seg_len      <= '0;
      key_start    <= '0;
      key_len      <= '0;
      value_begin  <= '0;
      value_count  <= '0;
    end else if (accept) begin
      st           <= st_next;
      position     <= position_next;
      scheme_start <= scheme_start_next;
      host_start   <= host_start_next;
      host_len     <= host_len_next;
      port_start   <= port_start_next;
      port_len     <= port_len_next;
      path_base    <= path_base_next;
      path_len     <= path_len_next;
      seg_start    <= seg_start_next;
      seg_len      <= seg_len_next;
      key_start    <= key_start_next;
      key_len      <= key_len_next;
      value_begin  <= value_begin_next;
      value_count  <= value_count_next;
    end
  end

endmodule

// ===== hdl/usp_queue.sv =====
module usp_queue import usp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    head_valid,
  output bundle_t head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/usp_back.sv =====
module usp_back import usp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  bundle_t   head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res
);

  logic [1:0] idx;
  logic       load;
  logic       final_ev;
  ev_t        cur;

  assign load     = head_valid && (!res_valid || !res_stall);
  assign final_ev = (idx == head.count - 2'd1);
  assign cur      = head.evs[idx];
  assign pop      = load && final_ev;

  // walk through the head bundle one event per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= final_ev ? 2'd0 : idx + 2'd1;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      res.event_res   <= cur.code;
      res.span_start  <= cur.start;
      res.span_len    <= cur.len;
      res.value_start <= cur.vstart;
      res.value_len   <= cur.vlen;
      res.last        <= final_ev;
    end
  end

endmodule

// ===== hdl/url_stream_parser.sv =====
// each result is written into the queue and then into the output register before it is valid
// the parser takes one byte per cycle unless the queue is full; the output register sends
// one result per cycle unless res_stall is high, one transfer for each result of a byte
// a four-entry queue between parser and output lets either side stall on its own
// reset (synchronous, active high): parser back to start, position and spans zero,
// queue empty, event enable mask all ones
module url_stream_parser import usp_pkg::*; #(
  parameter int MAX_URL_LEN = MAX_URL_LEN_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        res_valid,
  input  logic        res_stall,
  output out_item_t   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       accept;
  logic       push, pop, full, head_valid;
  bundle_t    push_data, head;
  logic [7:0] event_mask;

  assign pready     = 1'b1;
  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_mask <= 8'hFF;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EVENT_MASK) begin
      event_mask <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_EVENT_MASK) ? {24'd0, event_mask} : 32'd0;

  usp_front #(
    .MAX_URL_LEN(MAX_URL_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .event_mask (event_mask),
    .push       (push),
    .bundle     (push_data)
  );

  usp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  usp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

// ===== sim/url_stream_parser_tb.sv =====
`timescale 1ns / 1ps

module url_stream_parser_tb;
  import usp_pkg::*;

  localparam int URL_LIMIT = MAX_URL_LEN_DEFAULT;
  localparam logic [2:0] MASK_ADDR = 3'(4 * int'(REG_EVENT_MASK));

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  out_item_t   res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  url_stream_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // byte and end-command transfers waiting to be sent, and the url being built
  in_item_t   pending_bytes[$];
  logic [7:0] url_buf[$];
  // events the parser should report, oldest first
  out_item_t  expected_events[$];

  int   fail_count = 0;
  int   tx_idle_pct = 21;
  int   rx_idle_pct = 21;
  logic item_taken = 1'b0;

  // character sets for random url content
  string plain_set = "abcmxyzAKQZ0359-._~!$'()*+,;@#[]";
  string key_set   = "abcxyzQ07-._~!$*+@&&";
  string value_set = "abcxyzQ07-._~!$*+@==";

  // parser model state
  parse_state_t pst;
  logic [7:0]   event_mask;
  logic [12:0]  upos;
  logic [12:0]  scheme_at, host_at, host_n, port_at, port_n, path_at, path_n;
  logic [12:0]  seg_at, seg_n, key_at, key_n, val_at, val_n;
  int           step_events;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic url_char_ok(logic [7:0] c);
    string punct = "-._~:/?#[]@!$&'()*+,;=";
    if (c >= "0" && c <= "9") return 1'b1;
    if (c >= "A" && c <= "Z") return 1'b1;
    if (c >= "a" && c <= "z") return 1'b1;
    for (int k = 0; k < punct.len(); k++)
      if (punct[k] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [11:0] clamp_off(logic [12:0] v);
    return (v > 13'd4095) ? 12'd4095 : v[11:0];
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("ev %0d start %0d len %0d vstart %0d vlen %0d last %0d",
                     r.event_res, r.span_start, r.span_len, r.value_start,
                     r.value_len, r.last);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic clear_parse();
    pst = ST_START;
    upos = '0;
    scheme_at = '0;
    host_at = '0;
    host_n = '0;
    port_at = '0;
    port_n = '0;
    path_at = '0;
    path_n = '0;
    seg_at = '0;
    seg_n = '0;
    key_at = '0;
    key_n = '0;
    val_at = '0;
    val_n = '0;
  endtask

  // queue one event unless masked; error is never masked
  task automatic post_event(event_t ev, logic [12:0] s, logic [12:0] l,
                            logic [12:0] vs, logic [12:0] vl);
    out_item_t r;
    if (ev != EV_ERROR && event_mask[ev[2:0]] == 1'b0) return;
    if (step_events >= EV_SLOTS) return;
    r.event_res = ev;
    r.span_start = clamp_off(s);
    r.span_len = l;
    r.value_start = clamp_off(vs);
    r.value_len = vl;
    r.last = 1'b0;
    expected_events.push_back(r);
    step_events++;
  endtask

  task automatic open_path(logic [12:0] p);
    pst = ST_SEGMENT;
    path_at = p;
    path_n++;
    seg_at = p + 13'd1;
  endtask

  // advance the parser model by one accepted transfer
  task automatic predict_item(in_item_t it);
    logic [12:0] p;
    logic [7:0]  c;
    logic        bad;
    p = upos;
    c = it.ch;
    bad = 1'b0;
    step_events = 0;
    if (it.cmd == CMD_END) begin
      // flush the open field, then complete or error
      case (pst)
        ST_SEGMENT: begin
          post_event(EV_SEGMENT, seg_at, seg_n, 13'd0, 13'd0);
          post_event(EV_PATH, path_at, path_n, 13'd0, 13'd0);
        end
        ST_VALUE: post_event(EV_KV, key_at, key_n, val_at, val_n);
        ST_HOST:  post_event(EV_HOST, host_at, host_n, 13'd0, 13'd0);
        ST_PORT:  post_event(EV_PORT, port_at, port_n, 13'd0, 13'd0);
        default:  bad = 1'b1;
      endcase
      if (bad) post_event(EV_ERROR, p, 13'd0, 13'd0, 13'd0);
      else post_event(EV_COMPLETE, 13'd0, p, 13'd0, 13'd0);
      clear_parse();
    end else if (pst != ST_ERROR) begin
      if (p >= URL_LIMIT || !url_char_ok(c)) begin
        bad = 1'b1;
      end else begin
        case (pst)
          ST_START: begin
            post_event(EV_BEGIN, 13'd0, 13'd0, 13'd0, 13'd0);
            if (c == CH_SLASH) begin
              open_path(p);
            end else begin
              pst = ST_SCHEME;
              scheme_at = p;
            end
          end
          ST_SCHEME: begin
            if (c == CH_COLON) begin
              post_event(EV_SCHEME, scheme_at, p - scheme_at, 13'd0, 13'd0);
              pst = ST_SLASH1;
            end
          end
          ST_SLASH1: begin
            if (c == CH_SLASH) pst = ST_SLASH2;
            else bad = 1'b1;
          end
          ST_SLASH2: begin
            if (c == CH_SLASH) begin
              pst = ST_HOST;
              host_at = p + 13'd1;
            end else begin
              bad = 1'b1;
            end
          end
          ST_HOST: begin
            if (c == CH_COLON || c == CH_SLASH) begin
              post_event(EV_HOST, host_at, host_n, 13'd0, 13'd0);
              if (c == CH_COLON) pst = ST_PRECOLON;
              else open_path(p);
            end else begin
              host_n++;
            end
          end
          ST_PRECOLON: begin
            if (c == CH_SLASH) begin
              bad = 1'b1;
            end else begin
              pst = ST_PORT;
              port_at = p;
              port_n = 13'd1;
            end
          end
          ST_PORT: begin
            if (c == CH_SLASH) begin
              post_event(EV_PORT, port_at, port_n, 13'd0, 13'd0);
              open_path(p);
            end else begin
              port_n++;
            end
          end
          ST_SEGMENT: begin
            if (c == CH_SLASH || c == CH_QUESTION) begin
              post_event(EV_SEGMENT, seg_at, seg_n, 13'd0, 13'd0);
              seg_at = p + 13'd1;
              seg_n = '0;
            end else begin
              seg_n++;
            end
            if (c == CH_QUESTION) begin
              post_event(EV_PATH, path_at, path_n, 13'd0, 13'd0);
              pst = ST_KEY;
              key_at = p + 13'd1;
              key_n = '0;
            end else begin
              path_n++;
            end
          end
          ST_KEY: begin
            if (c == CH_EQUALS) begin
              pst = ST_VALUE;
              val_at = p + 13'd1;
              val_n = '0;
            end else begin
              key_n++;
            end
          end
          ST_VALUE: begin
            if (c == CH_AMP) begin
              post_event(EV_KV, key_at, key_n, val_at, val_n);
              pst = ST_KEY;
              key_at = p + 13'd1;
              key_n = '0;
            end else begin
              val_n++;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        pst = ST_ERROR;
        post_event(EV_ERROR, p, 13'd0, 13'd0, 13'd0);
      end
      if (p < URL_LIMIT) upos = p + 13'd1;
    end
    if (step_events > 0) expected_events[expected_events.size()-1].last = 1'b1;
  endtask

  // driver: new transfer at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        item_valid <= 1'b1;
        item <= pending_bytes.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin : monitor
    out_item_t want;
    item_taken = !rst && item_valid && !item_stall;
    if (item_taken) predict_item(item);
    if (!rst && res_valid && !res_stall) begin
      if (expected_events.size() == 0) begin
        note_failure({"result with none expected: ", describe(res)});
      end else begin
        want = expected_events.pop_front();
        if (res.event_res !== want.event_res || res.span_start !== want.span_start ||
            res.span_len !== want.span_len || res.value_start !== want.value_start ||
            res.value_len !== want.value_len || res.last !== want.last)
          note_failure({"expected ", describe(want), " got ", describe(res)});
      end
    end
  end

  // url building helpers
  task automatic add_string(string s);
    for (int k = 0; k < s.len(); k++) url_buf.push_back(s[k]);
  endtask

  task automatic add_chars(int n, string alphabet);
    repeat (n) url_buf.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
  endtask

  // move the built url to the send queue, closed by an end command
  task automatic commit_url();
    in_item_t t;
    foreach (url_buf[k]) begin
      t.cmd = CMD_CHAR;
      t.ch = url_buf[k];
      pending_bytes.push_back(t);
    end
    t.cmd = CMD_END;
    t.ch = 8'($urandom);
    pending_bytes.push_back(t);
    url_buf.delete();
  endtask

  // mostly well-formed urls with random content, some noise and breakage
  task automatic build_random_url();
    int form;
    int n;
    form = $urandom_range(99);
    if (form < 12) begin
      repeat ($urandom_range(1, 6)) url_buf.push_back(8'($urandom));
    end else begin
      if (form < 30) begin
        url_buf.push_back(CH_SLASH);
      end else begin
        add_chars($urandom_range(1, 4), plain_set);
        add_string("://");
        add_chars($urandom_range(0, 4), plain_set);
        if ($urandom_range(1) == 1) begin
          url_buf.push_back(CH_COLON);
          add_chars($urandom_range(1, 3), plain_set);
        end
        if ($urandom_range(3) != 0) url_buf.push_back(CH_SLASH);
      end
      repeat ($urandom_range(0, 3)) begin
        add_chars($urandom_range(0, 3), plain_set);
        url_buf.push_back(CH_SLASH);
      end
      add_chars($urandom_range(0, 3), plain_set);
      if ($urandom_range(1) == 1) begin
        url_buf.push_back(CH_QUESTION);
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          add_chars($urandom_range(0, 3), key_set);
          if ($urandom_range(9) != 0) url_buf.push_back(CH_EQUALS);
          add_chars($urandom_range(0, 3), value_set);
          if (k < n - 1) url_buf.push_back(CH_AMP);
        end
      end
      // corrupt one byte, or cut the tail off
      if (url_buf.size() != 0 && $urandom_range(99) < 15)
        url_buf[$urandom_range(url_buf.size() - 1)] = 8'($urandom);
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 3))
          if (url_buf.size() != 0) void'(url_buf.pop_back());
    end
  endtask

  // wait until everything sent has been answered and the block is quiet
  task automatic drain();
    while (pending_bytes.size() != 0 || item_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write of the event mask, then read it back
  task automatic write_event_mask(logic [7:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MASK_ADDR;
    pwdata <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    event_mask = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== v)
      note_failure($sformatf("event mask read %0h, wrote %0h", prdata[7:0], v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    logic [7:0] phase_masks [4];
    int queued;
    clear_parse();
    event_mask = 8'hFF;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    write_event_mask(8'hFF);

    // full url with '&' in the key and '=' in the value
    add_string("s://h:9/p?k&=v=");
    commit_url();
    // bare root path
    add_string("/");
    commit_url();
    // illegal percent, then a high byte in the error state
    add_string("%");
    url_buf.push_back(8'hFF);
    commit_url();
    // slash straight after the port colon
    add_string("x://h:/");
    commit_url();
    drain();

    // random urls under several mask settings; the all-ones phase runs with no idling
    phase_masks[0] = 8'h00;
    phase_masks[1] = 8'hFF;
    phase_masks[2] = 8'($urandom);
    phase_masks[3] = 8'hA5;
    foreach (phase_masks[m]) begin
      drain();
      tx_idle_pct = (m == 1) ? 0 : 21;
      rx_idle_pct = (m == 1) ? 0 : 21;
      write_event_mask(phase_masks[m]);
      queued = 0;
      while (queued < 60) begin
        build_random_url();
        queued += url_buf.size() + 1;
        commit_url();
      end
    end

    // wind down
    while (pending_bytes.size() != 0 || item_valid) @(posedge clk);
    for (int k = 0; k < 20000 && expected_events.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_events.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_events.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== url_stream_parser.f =====
hdl/usp_pkg.sv
hdl/usp_front.sv
hdl/usp_queue.sv
hdl/usp_back.sv
hdl/url_stream_parser.sv
sim/url_stream_parser_tb.sv
